// ----- src/rlve_pkg.sv -----
// ----------------------------------------------------------------------------
// rlve_pkg
// Shared types, widths and constants of the rectangular light vector block.
// ----------------------------------------------------------------------------
package rlve_pkg;

  // field widths
  localparam int W_POS  = 32;
  localparam int W_REG  = 24;
  localparam int W_ADDR = 5;
  localparam int W_DATA = 32;
  localparam int W_LIMB = 32;

  // datapath widths, all magnitudes
  localparam int W_MAG  = 32;
  localparam int W_SQ   = 63;
  localparam int W_RR   = 64;
  localparam int W_LL   = 48;
  localparam int W_CF   = 50;
  localparam int W_AXY  = W_SQ + W_LL;
  localparam int W_CFR  = W_CF + W_RR;
  localparam int W_RR2  = 2 * W_RR;
  localparam int W_P    = 132;
  localparam int W_NZ   = W_P + W_MAG;
  localparam int W_NC   = W_NZ + W_MAG;
  localparam int W_K    = 29;
  localparam int W_NK   = W_NC + W_K;
  localparam int W_U    = W_NK + W_REG;
  localparam int W_DEN4 = 2 * W_RR2;
  localparam int W_DEN  = W_DEN4 + 3;
  localparam int W_Q    = 33;

  // 1/(4*pi) in Q0.32
  localparam logic [W_K-1:0]   INV4PI    = 29'd341782638;
  localparam logic [W_REG-1:0] REG_RESET = 24'h010000;

  localparam int QUEUE_DEPTH = 2;
  localparam int W_QPTR      = $clog2(QUEUE_DEPTH);
  localparam int W_QCNT      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDX_LENGTH,
    IDX_WIDTH,
    IDX_RED,
    IDX_GREEN,
    IDX_BLUE
  } cfg_idx_t;

  typedef struct packed {
    logic signed [W_POS-1:0] pos_x;
    logic signed [W_POS-1:0] pos_y;
    logic signed [W_POS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [W_POS-1:0] red_vx;
    logic signed [W_POS-1:0] red_vy;
    logic signed [W_POS-1:0] red_vz;
    logic signed [W_POS-1:0] green_vx;
    logic signed [W_POS-1:0] green_vy;
    logic signed [W_POS-1:0] green_vz;
    logic signed [W_POS-1:0] blue_vx;
    logic signed [W_POS-1:0] blue_vy;
    logic signed [W_POS-1:0] blue_vz;
    logic                    saturated;
    logic                    degenerate;
  } out_item_t;

  typedef struct packed {
    logic [W_REG-1:0] rect_length;
    logic [W_REG-1:0] rect_width;
    logic [W_REG-1:0] irr_red;
    logic [W_REG-1:0] irr_green;
    logic [W_REG-1:0] irr_blue;
  } cfg_regs_t;

  // classified point: magnitudes and signs of x, y, z
  typedef struct packed {
    logic [2:0][W_MAG-1:0] mag;
    logic [2:0]            sgn;
    logic                  degen;
  } pt_item_t;

  function automatic int mul_lat(input int wa, input int wb);
    return ((wa + W_LIMB - 1) / W_LIMB) * ((wb + W_LIMB - 1) / W_LIMB);
  endfunction

endpackage

// ----- src/rlve_dly.sv -----
// ----------------------------------------------------------------------------
// rlve_dly
// Balancing register line that keeps side data in step with the datapath.
// ----------------------------------------------------------------------------
module rlve_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (ce) begin
      sh_r[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign q = sh_r[DEPTH-1];

endmodule

// ----- src/rlve_mul.sv -----
// ----------------------------------------------------------------------------
// rlve_mul
// Pipelined wide unsigned multiplier, one 32x32 limb product per stage.
// ----------------------------------------------------------------------------
module rlve_mul import rlve_pkg::*; #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA  = (WA + W_LIMB - 1) / W_LIMB;
  localparam int NB  = (WB + W_LIMB - 1) / W_LIMB;
  localparam int NS  = NA * NB;
  localparam int WAP = NA * W_LIMB;
  localparam int WBP = NB * W_LIMB;
  localparam int WP  = WA + WB;

  logic [WAP-1:0] a_r   [NS];
  logic [WBP-1:0] b_r   [NS];
  logic [WP-1:0]  acc_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int LI = s % NA;
    localparam int LJ = s / NA;
    logic [WAP-1:0]        a_in;
    logic [WBP-1:0]        b_in;
    logic [WP-1:0]         acc_in;
    logic [2*W_LIMB-1:0]   prod;

    if (s == 0) begin : g_first
      assign a_in   = WAP'(a);
      assign b_in   = WBP'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[s-1];
      assign b_in   = b_r[s-1];
      assign acc_in = acc_r[s-1];
    end

    assign prod = a_in[W_LIMB*LI +: W_LIMB] * b_in[W_LIMB*LJ +: W_LIMB];

    always_ff @(posedge clk) begin
      if (ce) begin
        a_r[s]   <= a_in;
        b_r[s]   <= b_in;
        acc_r[s] <= acc_in + (WP'(prod) << (W_LIMB * (LI + LJ)));
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule

// ----- src/rlve_div.sv -----
// ----------------------------------------------------------------------------
// rlve_div
// Pipelined restoring divider, one quotient bit per stage, msb first.
// ----------------------------------------------------------------------------
module rlve_div #(
  parameter int WN = 64,
  parameter int WD = 64,
  parameter int WQ = 33
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  output logic [WQ-1:0] q
);

  localparam int WT = WD + WQ - 1;

  logic [WN-1:0] rem_r [WQ];
  logic [WD-1:0] den_r [WQ];
  logic [WQ-1:0] q_r   [WQ];

  for (genvar s = 0; s < WQ; s++) begin : g_stage
    localparam int SH = WQ - 1 - s;
    logic [WN-1:0] rem_in;
    logic [WD-1:0] den_in;
    logic [WQ-1:0] q_in;
    logic [WT-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign trial = WT'(den_in) << SH;
    assign ge    = (WT'(rem_in) >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s] <= ge ? (rem_in - trial[WN-1:0]) : rem_in;
        den_r[s] <= den_in;
        q_r[s]   <= {q_in[WQ-2:0], ge};
      end
    end
  end

  assign q = q_r[WQ-1];

endmodule

// ----- src/rlve_front.sv -----
// ----------------------------------------------------------------------------
// rlve_front
// Accepts shading points, splits them into sign and magnitude, flags the
// origin and queues them for the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rlve_front import rlve_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output pt_item_t q_item,
  input  logic     q_pop
);

  pt_item_t          ent_r [QUEUE_DEPTH];
  logic [W_QPTR-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [W_QPTR-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [W_QCNT-1:0] cnt_r, cnt_nxt;
  logic [2:0][W_POS-1:0] raw;
  pt_item_t          cls;
  logic              push;

  assign raw = {in_data.pos_z, in_data.pos_y, in_data.pos_x};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cls.sgn[c] = raw[c][W_POS-1];
      cls.mag[c] = raw[c][W_POS-1] ? (~raw[c] + W_MAG'(1)) : raw[c];
    end
    cls.degen = (raw == '0);
  end

  assign in_stall = (cnt_r == W_QCNT'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == W_QPTR'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == W_QPTR'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= W_QCNT'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty queue");

endmodule

// ----- src/rlve_back.sv -----
// ----------------------------------------------------------------------------
// rlve_back
// Exact fixed-point pipeline: builds numerator and denominator as wide
// integers, divides the nine components and saturates them.
// ----------------------------------------------------------------------------
module rlve_back import rlve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  pt_item_t  q_item,
  output logic      q_pop,
  input  cfg_regs_t cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // stage timing, counted in pipeline advances after the pop
  localparam int T_SQ = mul_lat(W_MAG, W_MAG);
  localparam int T_B  = T_SQ + 1;
  localparam int T_C  = T_B + mul_lat(W_RR, W_RR);
  localparam int T_P  = T_C + 1;
  localparam int T_N  = T_P + 1;
  localparam int T_NZ = T_N + mul_lat(W_P, W_MAG);
  localparam int T_NC = T_NZ + mul_lat(W_NZ, W_MAG);
  localparam int T_NK = T_NC + mul_lat(W_NC, W_K);
  localparam int T_U  = T_NK + mul_lat(W_NK, W_REG);
  localparam int T_D  = T_C + mul_lat(W_RR2, W_RR2) + 1;
  localparam int T_Q  = T_U + W_Q;

  logic      ce;
  logic      vld_r [T_Q];
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  assign ce    = !out_valid_r || !out_stall;
  assign q_pop = ce && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < T_Q; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= q_valid;
      for (int k = 1; k < T_Q; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[T_Q-1];
    end
  end

  // squares of the point and of the rectangle sides
  logic [2:0][2*W_MAG-1:0] sq_full;
  logic [W_LL-1:0]         ll, ww;

  for (genvar c = 0; c < 3; c++) begin : g_sq
    rlve_mul #(.WA(W_MAG), .WB(W_MAG)) u_sq (
      .clk(clk), .ce(ce), .a(q_item.mag[c]), .b(q_item.mag[c]), .p(sq_full[c])
    );
  end

  rlve_mul #(.WA(W_REG), .WB(W_REG)) u_ll (
    .clk(clk), .ce(ce), .a(cfg.rect_length), .b(cfg.rect_length), .p(ll)
  );
  rlve_mul #(.WA(W_REG), .WB(W_REG)) u_ww (
    .clk(clk), .ce(ce), .a(cfg.rect_width), .b(cfg.rect_width), .p(ww)
  );

  logic [W_RR-1:0]        rr_r;
  logic [2:0][W_CF-1:0]   cf_r;
  logic [W_SQ-1:0]        sqx_r, sqy_r;
  logic [W_LL-1:0]        ll_r, ww_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      rr_r     <= sq_full[0] + sq_full[1] + sq_full[2];
      cf_r[0]  <= (W_CF'(ll) << 1) + W_CF'(ll) + W_CF'(ww);
      cf_r[1]  <= W_CF'(ll) + (W_CF'(ww) << 1) + W_CF'(ww);
      cf_r[2]  <= W_CF'(ll) + W_CF'(ww);
      sqx_r    <= sq_full[0][W_SQ-1:0];
      sqy_r    <= sq_full[1][W_SQ-1:0];
      ll_r     <= ll;
      ww_r     <= ww;
    end
  end

  // second-order products
  logic [W_RR2-1:0]       rr2;
  logic [W_AXY-1:0]       ax, ay;
  logic [2:0][W_CFR-1:0]  cfr, cfr_p;

  rlve_mul #(.WA(W_RR), .WB(W_RR)) u_rr2 (
    .clk(clk), .ce(ce), .a(rr_r), .b(rr_r), .p(rr2)
  );
  rlve_mul #(.WA(W_SQ), .WB(W_LL)) u_ax (
    .clk(clk), .ce(ce), .a(sqx_r), .b(ll_r), .p(ax)
  );
  rlve_mul #(.WA(W_SQ), .WB(W_LL)) u_ay (
    .clk(clk), .ce(ce), .a(sqy_r), .b(ww_r), .p(ay)
  );
  for (genvar c = 0; c < 3; c++) begin : g_cfr
    rlve_mul #(.WA(W_CF), .WB(W_RR)) u_cfr (
      .clk(clk), .ce(ce), .a(cf_r[c]), .b(rr_r), .p(cfr[c])
    );
  end

  rlve_dly #(.W(3*W_CFR), .DEPTH(T_P - T_C)) u_cfr_dly (
    .clk(clk), .ce(ce), .d(cfr), .q(cfr_p)
  );

  // denominator 6*rr^4
  logic [W_DEN4-1:0] den4;
  logic [W_DEN-1:0]  den_r, den_u;

  rlve_mul #(.WA(W_RR2), .WB(W_RR2)) u_den4 (
    .clk(clk), .ce(ce), .a(rr2), .b(rr2), .p(den4)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      den_r <= (W_DEN'(den4) << 2) + (W_DEN'(den4) << 1);
    end
  end

  rlve_dly #(.W(W_DEN), .DEPTH(T_U - T_D)) u_den_dly (
    .clk(clk), .ce(ce), .d(den_r), .q(den_u)
  );

  // numerator core 6(rr^2 + x^2 l^2 + y^2 w^2) - c*rr, as sign and magnitude
  logic [W_P-1:0]        psum;
  logic [W_P-1:0]        p_r;
  logic [2:0][W_P-1:0]   n_r;
  logic [2:0]            nneg_r;

  assign psum = W_P'(rr2) + W_P'(ax) + W_P'(ay);

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r <= (psum << 2) + (psum << 1);
      for (int c = 0; c < 3; c++) begin
        if (p_r >= W_P'(cfr_p[c])) begin
          n_r[c]    <= p_r - W_P'(cfr_p[c]);
          nneg_r[c] <= 1'b0;
        end else begin
          n_r[c]    <= W_P'(cfr_p[c]) - p_r;
          nneg_r[c] <= 1'b1;
        end
      end
    end
  end

  pt_item_t              item_n;
  logic [2:0]            neg_n;
  logic [3:0]            flags_q;
  logic [2:0][W_MAG-1:0] mag_nz;

  rlve_dly #(.W($bits(pt_item_t)), .DEPTH(T_N)) u_item_dly (
    .clk(clk), .ce(ce), .d(q_item), .q(item_n)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg_n[c] = nneg_r[c] ^ item_n.sgn[2] ^ item_n.sgn[c];
    end
  end

  rlve_dly #(.W(4), .DEPTH(T_Q - T_N)) u_flag_dly (
    .clk(clk), .ce(ce), .d({item_n.degen, neg_n}), .q(flags_q)
  );

  rlve_dly #(.W(3*W_MAG), .DEPTH(T_NZ - T_N)) u_mag_dly (
    .clk(clk), .ce(ce), .d(item_n.mag), .q(mag_nz)
  );

  // scale by z, coordinate, 1/(4pi) and irradiance, then divide
  logic [2:0][W_NZ-1:0]              nz;
  logic [2:0][W_NC-1:0]              nc;
  logic [2:0][W_NK-1:0]              nk;
  logic [2:0][W_REG-1:0]             irr;
  logic [2:0][2:0][W_U-1:0]          u;
  logic [2:0][2:0][W_Q-1:0]          quo;

  assign irr = {cfg.irr_blue, cfg.irr_green, cfg.irr_red};

  for (genvar c = 0; c < 3; c++) begin : g_comp
    rlve_mul #(.WA(W_P), .WB(W_MAG)) u_nz (
      .clk(clk), .ce(ce), .a(n_r[c]), .b(item_n.mag[2]), .p(nz[c])
    );
    rlve_mul #(.WA(W_NZ), .WB(W_MAG)) u_nc (
      .clk(clk), .ce(ce), .a(nz[c]), .b(mag_nz[c]), .p(nc[c])
    );
    rlve_mul #(.WA(W_NC), .WB(W_K)) u_nk (
      .clk(clk), .ce(ce), .a(nc[c]), .b(INV4PI), .p(nk[c])
    );
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      rlve_mul #(.WA(W_NK), .WB(W_REG)) u_irr (
        .clk(clk), .ce(ce), .a(nk[c]), .b(irr[ch]), .p(u[ch][c])
      );
      rlve_div #(.WN(W_U), .WD(W_DEN), .WQ(W_Q)) u_div (
        .clk(clk), .ce(ce), .num(u[ch][c]), .den(den_u), .q(quo[ch][c])
      );
    end
  end

  // clamp magnitude with sign into signed Q16.16, msb of result is the clamp
  function automatic logic [W_POS:0] encode(input logic [W_Q-1:0] q, input logic neg);
    logic [W_POS:0] res;
    if (!neg) begin
      if (q > W_Q'(32'h7FFF_FFFF)) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else begin
        res = {1'b0, q[W_POS-1:0]};
      end
    end else begin
      if (q > W_Q'(32'h8000_0000)) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, -q[W_POS-1:0]};
      end
    end
    return res;
  endfunction

  logic [2:0][2:0][W_POS:0] enc;
  logic [2:0][2:0][W_POS-1:0] comp;
  logic                     sat_any;

  always_comb begin
    sat_any = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        enc[ch][c]  = encode(quo[ch][c], flags_q[c]);
        comp[ch][c] = flags_q[3] ? '0 : enc[ch][c][W_POS-1:0];
        sat_any     = sat_any | enc[ch][c][W_POS];
      end
    end
    out_data_nxt.red_vx     = comp[0][0];
    out_data_nxt.red_vy     = comp[0][1];
    out_data_nxt.red_vz     = comp[0][2];
    out_data_nxt.green_vx   = comp[1][0];
    out_data_nxt.green_vy   = comp[1][1];
    out_data_nxt.green_vz   = comp[1][2];
    out_data_nxt.blue_vx    = comp[2][0];
    out_data_nxt.blue_vy    = comp[2][1];
    out_data_nxt.blue_vz    = comp[2][2];
    out_data_nxt.saturated  = sat_any && !flags_q[3];
    out_data_nxt.degenerate = flags_q[3];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.degenerate) |->
      (!out_data_r.saturated && out_data_r.red_vx == '0 && out_data_r.green_vy == '0 &&
       out_data_r.blue_vz == '0))
    else $error("origin point gave nonzero result");

endmodule

// ----- src/rect_light_vector_expansion_top.sv -----
// ----------------------------------------------------------------------------
// rect_light_vector_expansion_top
// Second-order light vector of a uniform rectangular area light, per colour
// channel, for a stream of shading points.
//
//   port group  handshake            payload
//   in_*        in_valid / in_stall  in_item_t  (pos_x, pos_y, pos_z)
//   out_*       out_valid/out_stall  out_item_t (nine components, flags)
//   apb         psel/penable/pready  five 24-bit registers at 4*i
//
// One point per clock sustained while out_stall is low; the delay from
// transfer in to out_valid is set by the chain of limb multipliers
// and the 33-stage restoring dividers.
// The whole pipeline holds while a result waits under out_stall; the
// two-entry input queue keeps taking points until it is full.
// Reset (synchronous, rst_n low) empties the queue and pipeline and loads
// every register with 1.0.
// ----------------------------------------------------------------------------
module rect_light_vector_expansion_top import rlve_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [W_ADDR-1:0] paddr,
  input  logic [W_DATA-1:0] pwdata,
  output logic [W_DATA-1:0] prdata,
  output logic              pready
);

  cfg_regs_t cfg_r, cfg_nxt;
  cfg_idx_t  idx;
  logic      wr_en;
  logic      q_valid, q_pop;
  pt_item_t  q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = cfg_idx_t'(paddr[W_ADDR-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        IDX_LENGTH: cfg_nxt.rect_length = pwdata[W_REG-1:0];
        IDX_WIDTH:  cfg_nxt.rect_width  = pwdata[W_REG-1:0];
        IDX_RED:    cfg_nxt.irr_red     = pwdata[W_REG-1:0];
        IDX_GREEN:  cfg_nxt.irr_green   = pwdata[W_REG-1:0];
        IDX_BLUE:   cfg_nxt.irr_blue    = pwdata[W_REG-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      IDX_LENGTH: prdata = W_DATA'(cfg_r.rect_length);
      IDX_WIDTH:  prdata = W_DATA'(cfg_r.rect_width);
      IDX_RED:    prdata = W_DATA'(cfg_r.irr_red);
      IDX_GREEN:  prdata = W_DATA'(cfg_r.irr_green);
      IDX_BLUE:   prdata = W_DATA'(cfg_r.irr_blue);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rect_length <= REG_RESET;
      cfg_r.rect_width  <= REG_RESET;
      cfg_r.irr_red     <= REG_RESET;
      cfg_r.irr_green   <= REG_RESET;
      cfg_r.irr_blue    <= REG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rlve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  rlve_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/rect_light_vector_expansion_top_test.sv -----
// ----------------------------------------------------------------------------
// rect_light_vector_expansion_top_test
// Self-checking bench for the rectangular light vector block: shading points
// stream in under random bursts and output stall, each light vector is
// predicted with wide exact integer arithmetic and compared field by field.
// Several register settings are loaded over apb between drained phases.
// ----------------------------------------------------------------------------
module rect_light_vector_expansion_top_test;
  import rlve_pkg::*;

  typedef logic [319:0] wide_t;

  localparam logic [2:0] IDX_UNMAPPED = 3'd5;
  localparam int         DRAIN_WAIT   = 100;
  localparam int         IDLE_LIMIT   = 5000;
  localparam logic [W_REG-1:0] REG_MAX = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [W_ADDR-1:0] paddr;
  logic [W_DATA-1:0] pwdata;
  logic [W_DATA-1:0] prdata;
  logic              pready;

  rect_light_vector_expansion_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the light registers
  logic [W_REG-1:0] light_len, light_wid, irr_r, irr_g, irr_b;

  in_item_t  point_queue[$];
  out_item_t vector_due[$];

  int errors;
  int points_sent;
  int vectors_seen;
  int sat_seen;
  int degen_seen;
  int settings_run;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on vector %0d, %s: got %h expected %h", vectors_seen, what, got, want);
  endtask

  function automatic logic [31:0] clamp_q16(wide_t q, bit neg, inout bit sat);
    if (!neg) begin
      if (q > wide_t'(32'h7FFF_FFFF)) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > wide_t'(32'h8000_0000)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return -q[31:0];
  endfunction

  function automatic out_item_t light_vector(in_item_t pt);
    longint     sv[3];
    wide_t      mag[3];
    bit         sg[3];
    wide_t      rr, ll, ww, pnum, cfr, nmag, den, q;
    wide_t      irr[3];
    bit         neg, sat;
    logic [31:0] comp[9];
    out_item_t  res;
    sv[0] = longint'(pt.pos_x);
    sv[1] = longint'(pt.pos_y);
    sv[2] = longint'(pt.pos_z);
    for (int c = 0; c < 3; c++) begin
      sg[c]  = sv[c] < 0;
      mag[c] = wide_t'(sg[c] ? -sv[c] : sv[c]);
    end
    res = '0;
    sat = 1'b0;
    rr = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    if (rr == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    ll  = wide_t'(light_len) * wide_t'(light_len);
    ww  = wide_t'(light_wid) * wide_t'(light_wid);
    irr[0] = wide_t'(irr_r);
    irr[1] = wide_t'(irr_g);
    irr[2] = wide_t'(irr_b);
    den  = 6 * rr * rr * rr * rr;
    pnum = 6 * (rr * rr + mag[0] * mag[0] * ll + mag[1] * mag[1] * ww);
    for (int c = 0; c < 3; c++) begin
      cfr = (c == 0) ? (3 * ll + ww) * rr : (c == 1) ? (ll + 3 * ww) * rr : (ll + ww) * rr;
      if (pnum >= cfr) begin
        nmag = pnum - cfr;
        neg  = 1'b0;
      end else begin
        nmag = cfr - pnum;
        neg  = 1'b1;
      end
      neg  = neg ^ sg[2] ^ sg[c];
      nmag = nmag * mag[2] * mag[c] * wide_t'(INV4PI);
      for (int ch = 0; ch < 3; ch++) begin
        q = (nmag * irr[ch]) / den;
        comp[ch * 3 + c] = clamp_q16(q, neg, sat);
      end
    end
    res.red_vx   = comp[0];
    res.red_vy   = comp[1];
    res.red_vz   = comp[2];
    res.green_vx = comp[3];
    res.green_vy = comp[4];
    res.green_vz = comp[5];
    res.blue_vx  = comp[6];
    res.blue_vy  = comp[7];
    res.blue_vz  = comp[8];
    res.saturated = sat;
    return res;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        vector_due.push_back(light_vector(in_data));
        points_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_data  <= point_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between free-running, sparse and heavy
  int stall_mode;
  int mode_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vector_due.size() == 0) begin
          report_mismatch("transfer with no vector due", out_data.red_vx, 32'h0);
        end else begin
          out_item_t want;
          want = vector_due.pop_front();
          if (out_data.red_vx !== want.red_vx)
            report_mismatch("red_vx", out_data.red_vx, want.red_vx);
          if (out_data.red_vy !== want.red_vy)
            report_mismatch("red_vy", out_data.red_vy, want.red_vy);
          if (out_data.red_vz !== want.red_vz)
            report_mismatch("red_vz", out_data.red_vz, want.red_vz);
          if (out_data.green_vx !== want.green_vx)
            report_mismatch("green_vx", out_data.green_vx, want.green_vx);
          if (out_data.green_vy !== want.green_vy)
            report_mismatch("green_vy", out_data.green_vy, want.green_vy);
          if (out_data.green_vz !== want.green_vz)
            report_mismatch("green_vz", out_data.green_vz, want.green_vz);
          if (out_data.blue_vx !== want.blue_vx)
            report_mismatch("blue_vx", out_data.blue_vx, want.blue_vx);
          if (out_data.blue_vy !== want.blue_vy)
            report_mismatch("blue_vy", out_data.blue_vy, want.blue_vy);
          if (out_data.blue_vz !== want.blue_vz)
            report_mismatch("blue_vz", out_data.blue_vz, want.blue_vz);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
          if (out_data.degenerate !== want.degenerate)
            report_mismatch("degenerate", 32'(out_data.degenerate), 32'(want.degenerate));
          sat_seen   += int'(want.saturated);
          degen_seen += int'(want.degenerate);
          vectors_seen++;
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2);
        mode_left  <= $urandom_range(60, 10);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(4) == 0);
        default: out_stall <= ($urandom_range(3) != 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d vectors outstanding", vector_due.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [W_DATA-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      IDX_LENGTH: light_len = value[W_REG-1:0];
      IDX_WIDTH:  light_wid = value[W_REG-1:0];
      IDX_RED:    irr_r     = value[W_REG-1:0];
      IDX_GREEN:  irr_g     = value[W_REG-1:0];
      IDX_BLUE:   irr_b     = value[W_REG-1:0];
      default: ;
    endcase
  endtask

  // upper byte carries junk that the block must drop
  task automatic load_light(logic [W_REG-1:0] len, logic [W_REG-1:0] wid,
                            logic [W_REG-1:0] r, logic [W_REG-1:0] g, logic [W_REG-1:0] b);
    reg_write(IDX_LENGTH, {8'($urandom), len});
    reg_write(IDX_WIDTH,  {8'($urandom), wid});
    reg_write(IDX_RED,    {8'($urandom), r});
    reg_write(IDX_GREEN,  {8'($urandom), g});
    reg_write(IDX_BLUE,   {8'($urandom), b});
    settings_run++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: return 32'($signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
      7, 8: return 32'($signed($urandom_range(32'h0000_3FFF)) - 32'sh0000_2000);
      default: return '0;
    endcase
  endfunction

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t pt;
    pt.pos_x = x;
    pt.pos_y = y;
    pt.pos_z = z;
    point_queue.push_back(pt);
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // waits for the queue to drain and the pipeline to go quiet
  task automatic drain();
    while (point_queue.size() > 0 || in_valid || vector_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    light_len = REG_RESET;
    light_wid = REG_RESET;
    irr_r = REG_RESET;
    irr_g = REG_RESET;
    irr_b = REG_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: origin, field extremes, axes, sign mixes
    queue_point(32'h0, 32'h0, 32'h0);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_point(32'h0, 32'h0, 32'h0001_0000);
    queue_point(32'h0, 32'h0, 32'hFFFF_0000);
    queue_point(32'h0001_0000, 32'h0, 32'h0);
    queue_point(32'h0, 32'h0001_0000, 32'h0000_8000);
    queue_point(32'h0000_0001, 32'h0, 32'h0);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_point(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
    queue_point(32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000);
    queue_point(32'hFFFD_0000, 32'h0001_8000, 32'hFFFF_0000);
    queue_point(32'h0000_4000, 32'h0000_4000, 32'h0000_2000);
    queue_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    queue_random(70);
    drain();

    // the sender holds off until every vector is back, then resumes
    load_light(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    reg_write(IDX_UNMAPPED, $urandom);
    queue_point(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
    queue_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    queue_point(32'h0, 32'h0, 32'h0);
    queue_random(80);
    drain();

    load_light('0, '0, '0, '0, '0);
    queue_point(32'h0001_0000, 32'h0, 32'h0001_0000);
    queue_random(40);
    drain();

    load_light('0, REG_MAX, 24'h008000, REG_MAX, 24'h000001);
    queue_random(60);
    drain();

    repeat (3) begin
      load_light(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom));
      queue_random(50);
      drain();
    end

    load_light(24'h020000, 24'h010000, 24'h010000, 24'h018000, 24'h008000);
    queue_random(100);
    drain();

    $display("covered %0d points over %0d light settings: %0d saturated, %0d at the origin",
             points_sent, settings_run, sat_seen, degen_seen);
    $display("%0d light vectors checked, %0d mismatches", vectors_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    errors       = 0;
    points_sent  = 0;
    vectors_seen = 0;
    sat_seen     = 0;
    degen_seen   = 0;
    settings_run = 0;
    idle_cycles  = 0;
  end

endmodule
